[src/rtos_ready_bitmap_scheduler_defines.svh]
// Assertion macros used by the scheduler back end (rrbs_back).
`ifndef RTOS_READY_BITMAP_SCHEDULER_DEFINES_SVH
`define RTOS_READY_BITMAP_SCHEDULER_DEFINES_SVH
`ifndef SYNTHESIS
`define RRBS_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RRBS_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
	`RRBS_ASSERT(label, clk, rst_n, !(expr), msg)
`else
`define RRBS_ASSERT(label, clk, rst_n, prop, msg)
`define RRBS_ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

[src/rrbs_pkg.sv]
`timescale 1ns / 1ps
package rrbs_pkg;

	localparam int NUM_TASKS = 64;
	localparam int WORD_BITS = 32;
	localparam int BIT_W     = 5;
	localparam int NUM_WORDS = (NUM_TASKS + WORD_BITS - 1) / WORD_BITS;
	localparam int GRP_W     = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam int IDX_W     = $clog2(NUM_TASKS);
	localparam int OP_W      = 2;
	localparam int TASK_W    = 6;
	localparam int DELAY_W   = 16;
	localparam int TICK_W    = 32;
	localparam int QPTR_W    = 1;
	localparam int QDEPTH    = 2;
	localparam int QCNT_W    = 2;

	typedef enum logic [OP_W-1:0] {
		OP_TICK  = 2'd0,
		OP_SET   = 2'd1,
		OP_CLEAR = 2'd2,
		OP_DELAY = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_DISABLED = 2'd1,
		ST_RANGE    = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		K_TICK  = 3'd0,
		K_SET   = 3'd1,
		K_CLEAR = 3'd2,
		K_DELAY = 3'd3,
		K_NONE  = 3'd4
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		status_t            status;
		logic [IDX_W-1:0]   task_idx;
		logic [DELAY_W-1:0] ticks;
	} cmd_t;

	typedef struct packed {
		logic [TASK_W-1:0] highest;
		logic              any;
		logic [TICK_W-1:0] tick_count;
		status_t           status;
	} res_t;

endpackage

[src/rrbs_ram.sv]
`timescale 1ns / 1ps
module rrbs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[src/rrbs_front.sv]
`timescale 1ns / 1ps
module rrbs_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic                           cfg_wdata,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [rrbs_pkg::OP_W-1:0]      in_opcode,
	input  logic [rrbs_pkg::TASK_W-1:0]    in_task,
	input  logic [rrbs_pkg::DELAY_W-1:0]   in_ticks,
	output logic                           cmd_valid,
	input  logic                           cmd_ready,
	output rrbs_pkg::cmd_t                 cmd
);

	logic                          enable_q;
	rrbs_pkg::cmd_t                fifo_q [rrbs_pkg::QDEPTH];
	logic [rrbs_pkg::QPTR_W-1:0]   wr_ptr_q;
	logic [rrbs_pkg::QPTR_W-1:0]   rd_ptr_q;
	logic [rrbs_pkg::QCNT_W-1:0]   cnt_q;
	rrbs_pkg::cmd_t                cls;
	rrbs_pkg::op_t                 op;
	logic                          push;
	logic                          pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
		end else if (cfg_we) begin
			enable_q <= cfg_wdata;
		end
	end

	// Classify at accept: ticks while stopped and out-of-range tasks become no-ops.
	always_comb begin
		op           = rrbs_pkg::op_t'(in_opcode);
		cls.task_idx = rrbs_pkg::IDX_W'(in_task);
		cls.ticks    = in_ticks;
		cls.status   = rrbs_pkg::ST_OK;
		cls.kind     = rrbs_pkg::K_NONE;
		if (op == rrbs_pkg::OP_TICK) begin
			if (enable_q) begin
				cls.kind = rrbs_pkg::K_TICK;
			end else begin
				cls.status = rrbs_pkg::ST_DISABLED;
			end
		end else if (32'(in_task) >= 32'(rrbs_pkg::NUM_TASKS)) begin
			cls.status = rrbs_pkg::ST_RANGE;
		end else begin
			case (op)
				rrbs_pkg::OP_SET:   cls.kind = rrbs_pkg::K_SET;
				rrbs_pkg::OP_CLEAR: cls.kind = rrbs_pkg::K_CLEAR;
				rrbs_pkg::OP_DELAY: cls.kind = rrbs_pkg::K_DELAY;
				default:            cls.kind = rrbs_pkg::K_NONE;
			endcase
		end
	end

	assign in_ready  = cnt_q != rrbs_pkg::QCNT_W'(rrbs_pkg::QDEPTH);
	assign cmd_valid = cnt_q != '0;
	assign cmd       = fifo_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = cmd_valid && cmd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

[src/rrbs_back.sv]
`timescale 1ns / 1ps
`include "rtos_ready_bitmap_scheduler_defines.svh"
module rrbs_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	output logic            cmd_ready,
	input  rrbs_pkg::cmd_t  cmd,
	output logic            res_valid,
	input  logic            res_ready,
	output rrbs_pkg::res_t  res
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_WALK = 4'b0010,
		S_FIND = 4'b0100,
		S_PICK = 4'b1000
	} state_t;

	localparam logic [rrbs_pkg::IDX_W-1:0] LAST_IDX = rrbs_pkg::IDX_W'(rrbs_pkg::NUM_TASKS - 1);
	localparam int PAD_W = rrbs_pkg::NUM_WORDS * rrbs_pkg::WORD_BITS;

	state_t                           state_q;
	logic [rrbs_pkg::NUM_TASKS-1:0]   ready_q;
	logic [rrbs_pkg::NUM_TASKS-1:0]   dvalid_q;
	logic [rrbs_pkg::TICK_W-1:0]      tick_q;
	logic [rrbs_pkg::IDX_W-1:0]       idx_q;
	rrbs_pkg::status_t                status_q;
	logic [rrbs_pkg::GRP_W-1:0]       grp_q;
	logic                             any_q;

	logic                             pop;
	logic                             ram_we;
	logic [rrbs_pkg::IDX_W-1:0]       ram_waddr;
	logic [rrbs_pkg::DELAY_W-1:0]     ram_wdata;
	logic                             ram_re;
	logic [rrbs_pkg::IDX_W-1:0]       ram_raddr;
	logic [rrbs_pkg::DELAY_W-1:0]     ram_rdata;
	logic [rrbs_pkg::DELAY_W-1:0]     cur;
	logic [PAD_W-1:0]                 ready_pad;
	logic [rrbs_pkg::WORD_BITS-1:0]   words [rrbs_pkg::NUM_WORDS];
	logic [rrbs_pkg::GRP_W-1:0]       grp_sel;
	logic                             grp_any;
	logic [rrbs_pkg::BIT_W-1:0]       bit_sel;
	logic [rrbs_pkg::GRP_W+rrbs_pkg::BIT_W-1:0] hi_full;

	rrbs_ram #(
		.WIDTH (rrbs_pkg::DELAY_W),
		.DEPTH (rrbs_pkg::NUM_TASKS)
	) u_delay_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign cmd_ready = state_q == S_IDLE;
	assign pop       = cmd_valid && cmd_ready;

	// An entry never written since reset reads as zero.
	assign cur = dvalid_q[idx_q] ? ram_rdata : '0;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = cur - 1'b1;
		ram_re    = 1'b0;
		ram_raddr = idx_q + 1'b1;
		case (state_q)
			S_IDLE: begin
				if (pop && cmd.kind == rrbs_pkg::K_DELAY) begin
					ram_we    = 1'b1;
					ram_waddr = cmd.task_idx;
					ram_wdata = cmd.ticks;
				end
				if (pop && cmd.kind == rrbs_pkg::K_TICK) begin
					ram_re    = 1'b1;
					ram_raddr = '0;
				end
			end
			S_WALK: begin
				ram_we = cur != '0;
				ram_re = idx_q != LAST_IDX;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// Two-level search: highest nonempty word, then highest bit in it.
	always_comb begin
		ready_pad = PAD_W'(ready_q);
		for (int w = 0; w < rrbs_pkg::NUM_WORDS; w++) begin
			words[w] = ready_pad[w*rrbs_pkg::WORD_BITS +: rrbs_pkg::WORD_BITS];
		end
		grp_sel = '0;
		grp_any = 1'b0;
		for (int w = 0; w < rrbs_pkg::NUM_WORDS; w++) begin
			if (words[w] != '0) begin
				grp_sel = rrbs_pkg::GRP_W'(w);
				grp_any = 1'b1;
			end
		end
		bit_sel = '0;
		for (int b = 0; b < rrbs_pkg::WORD_BITS; b++) begin
			if (words[grp_q][b]) begin
				bit_sel = rrbs_pkg::BIT_W'(b);
			end
		end
		hi_full = any_q ? {grp_q, bit_sel} : '0;
	end

	assign res_valid      = state_q == S_PICK;
	assign res.highest    = rrbs_pkg::TASK_W'(hi_full);
	assign res.any        = any_q;
	assign res.tick_count = tick_q;
	assign res.status     = status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ready_q  <= '0;
			dvalid_q <= '0;
			tick_q   <= '0;
			idx_q    <= '0;
			status_q <= rrbs_pkg::ST_OK;
			grp_q    <= '0;
			any_q    <= 1'b0;
		end else begin
			if (ram_we) begin
				dvalid_q[ram_waddr] <= 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (pop) begin
						status_q <= cmd.status;
						idx_q    <= '0;
						state_q  <= S_FIND;
						case (cmd.kind)
							rrbs_pkg::K_TICK: begin
								tick_q  <= tick_q + 1'b1;
								state_q <= S_WALK;
							end
							rrbs_pkg::K_SET: begin
								ready_q[cmd.task_idx] <= 1'b1;
							end
							rrbs_pkg::K_CLEAR: begin
								ready_q[cmd.task_idx] <= 1'b0;
							end
							rrbs_pkg::K_DELAY: begin
								if (cmd.ticks != '0) begin
									ready_q[cmd.task_idx] <= 1'b0;
								end
							end
							default: begin
								ready_q <= ready_q;
							end
						endcase
					end
				end
				S_WALK: begin
					// Wake the task whose counter runs out on this tick.
					if (cur == rrbs_pkg::DELAY_W'(1)) begin
						ready_q[idx_q] <= 1'b1;
					end
					idx_q <= idx_q + 1'b1;
					if (idx_q == LAST_IDX) begin
						state_q <= S_FIND;
					end
				end
				S_FIND: begin
					grp_q   <= grp_sel;
					any_q   <= grp_any;
					state_q <= S_PICK;
				end
				S_PICK: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`RRBS_ASSERT(a_walk_step, clk, arst_n, (state_q == S_WALK && idx_q != LAST_IDX) |=> (state_q == S_WALK && idx_q == $past(idx_q) + 1'b1), "delay walk skipped an entry")
	`RRBS_ASSERT(a_walk_end, clk, arst_n, (state_q == S_WALK && idx_q == LAST_IDX) |=> state_q == S_FIND, "delay walk did not finish into search")
	`RRBS_ASSERT_NEVER(a_ram_we_state, clk, arst_n, ram_we && state_q != S_IDLE && state_q != S_WALK, "delay memory written outside idle or walk")
	`RRBS_ASSERT(a_tick_step, clk, arst_n, (tick_q != $past(tick_q)) |-> (tick_q == $past(tick_q) + 1'b1), "tick count moved by other than one")
	`RRBS_ASSERT(a_set_lands, clk, arst_n, $past(pop && cmd.kind == rrbs_pkg::K_SET) |-> ready_q[$past(cmd.task_idx)], "set ready did not reach the bitmap")

endmodule

[src/rtos_ready_bitmap_scheduler.sv]
`timescale 1ns / 1ps
// Two-level ready-bitmap task scheduler with a per-task delay counter memory.
// Each input beat is one operation (tick, set ready, clear ready, delay task) and yields
// one result beat with the highest ready task (0 when none), the any-ready flag, the tick
// count and a status. A two-entry command queue takes input beats at one per cycle while
// it has room, independent of the result side. Set, clear, delay and ignored ticks go
// through the search and pick states of the execution unit; an enabled tick first walks
// the delay memory (separate read and write ports), one counter per cycle.
// Delay counters reset to zero through per-entry valid flops, so no clearing pass is run.
// scheduler_enable (cfg_wdata) resets to 0; ticks taken while it is 0 report status 1.
module rtos_ready_bitmap_scheduler (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,       // scheduler_enable
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,    // [5:0] task_req, [21:6] delay_ticks
	input  logic [1:0]  s_axis_tuser,    // [1:0] opcode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata     // [5:0] highest_ready, [6] any_ready,
	                                     // [38:7] tick_count, [40:39] status
);

	logic           cmd_valid;
	logic           cmd_ready;
	rrbs_pkg::cmd_t cmd;
	logic           res_valid;
	logic           res_ready;
	rrbs_pkg::res_t res;
	logic           m_valid_q;
	rrbs_pkg::res_t m_data_q;

	rrbs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_opcode (s_axis_tuser),
		.in_task   (s_axis_tdata[5:0]),
		.in_ticks  (s_axis_tdata[21:6]),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd)
	);

	rrbs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// Hold the result beat until the sink takes it.
	assign res_ready = !m_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res_ready) begin
			m_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			m_data_q <= res;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {7'b0, m_data_q.status, m_data_q.tick_count, m_data_q.any,
		m_data_q.highest};

endmodule

[sim/rtos_ready_bitmap_scheduler_test.sv]
`timescale 1ns / 1ps
module rtos_ready_bitmap_scheduler_test;

	localparam int PHASES       = 6;
	localparam int PHASE_ITEMS  = 238;
	localparam int MAX_GAP      = 12;
	localparam bit [PHASES-1:0] PHASE_RUN   = 6'b101101;
	localparam bit [PHASES-1:0] PHASE_QUIET = 6'b010100;

	class sched_tracker;
		bit [rrbs_pkg::NUM_TASKS-1:0] ready_set;
		logic [rrbs_pkg::DELAY_W-1:0] delay_left[rrbs_pkg::NUM_TASKS];
		logic [rrbs_pkg::TICK_W-1:0]  tick_total;
		bit                           running;
		rrbs_pkg::res_t               pending_results[$];
		int                           mismatches;
		int                           beats_seen;

		function new();
			ready_set  = '0;
			tick_total = '0;
			running    = 1'b0;
			mismatches = 0;
			beats_seen = 0;
			foreach (delay_left[i]) delay_left[i] = '0;
		endfunction

		function int pending();
			return pending_results.size();
		endfunction

		// Apply one accepted operation and queue the result it must produce.
		function void predict_op(rrbs_pkg::op_t op, logic [rrbs_pkg::TASK_W-1:0] prio,
			logic [rrbs_pkg::DELAY_W-1:0] dly);
			rrbs_pkg::res_t    r;
			rrbs_pkg::status_t st;
			logic [rrbs_pkg::TASK_W-1:0] top;
			st = rrbs_pkg::ST_OK;
			if (op == rrbs_pkg::OP_TICK) begin
				if (!running) begin
					st = rrbs_pkg::ST_DISABLED;
				end else begin
					tick_total = tick_total + 1;
					for (int i = 0; i < rrbs_pkg::NUM_TASKS; i++) begin
						if (delay_left[i] != 0) begin
							delay_left[i] = delay_left[i] - 1'b1;
							if (delay_left[i] == 0) ready_set[i] = 1'b1;
						end
					end
				end
			end else if (int'(prio) >= rrbs_pkg::NUM_TASKS) begin
				st = rrbs_pkg::ST_RANGE;
			end else if (op == rrbs_pkg::OP_SET) begin
				ready_set[prio] = 1'b1;
			end else if (op == rrbs_pkg::OP_CLEAR) begin
				ready_set[prio] = 1'b0;
			end else begin
				delay_left[prio] = dly;
				if (dly != 0) ready_set[prio] = 1'b0;
			end
			top = '0;
			for (int i = 0; i < rrbs_pkg::NUM_TASKS; i++)
				if (ready_set[i]) top = i[rrbs_pkg::TASK_W-1:0];
			r.highest    = top;
			r.any        = |ready_set;
			r.tick_count = tick_total;
			r.status     = st;
			pending_results.push_back(r);
		endfunction

		task report(string msg);
			mismatches++;
			$display("[%0t] result beat %0d: %s", $realtime, beats_seen, msg);
		endtask

		task check_result(logic [47:0] beat);
			rrbs_pkg::res_t want;
			beats_seen++;
			if (pending_results.size() == 0) begin
				report("result beat with nothing expected");
				return;
			end
			want = pending_results.pop_front();
			if (beat[5:0] != want.highest)
				report($sformatf("highest_ready %0d, expected %0d", beat[5:0], want.highest));
			if (beat[6] != want.any)
				report($sformatf("any_ready %0d, expected %0d", beat[6], want.any));
			if (beat[38:7] != want.tick_count)
				report($sformatf("tick_count %0d, expected %0d", beat[38:7], want.tick_count));
			if (beat[40:39] != want.status)
				report($sformatf("status %0d, expected %0d", beat[40:39], want.status));
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_wdata = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata = '0;
	logic [1:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;

	bit           no_idle = 1'b0;
	sched_tracker sched = new();

	rtos_ready_bitmap_scheduler DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	always #2 clk = ~clk;

	task automatic send_op(rrbs_pkg::op_t op, logic [rrbs_pkg::TASK_W-1:0] prio,
		logic [rrbs_pkg::DELAY_W-1:0] dly);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {2'b00, dly, prio};
		s_axis_tuser  <= op;
		do @(posedge clk); while (!s_axis_tready);
		sched.predict_op(op, prio, dly);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (sched.pending() != 0) @(posedge clk);
	endtask

	task automatic set_running(bit on);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= on;
		@(posedge clk);
		cfg_we        <= 1'b0;
		sched.running = on;
	endtask

	task automatic send_random();
		int pick;
		int spread;
		rrbs_pkg::op_t op;
		logic [rrbs_pkg::TASK_W-1:0]  prio;
		logic [rrbs_pkg::DELAY_W-1:0] dly;
		pick = $urandom_range(0, 99);
		if (pick < 30) op = rrbs_pkg::OP_TICK;
		else if (pick < 50) op = rrbs_pkg::OP_SET;
		else if (pick < 78) op = rrbs_pkg::OP_CLEAR;
		else op = rrbs_pkg::OP_DELAY;
		prio = rrbs_pkg::TASK_W'($urandom_range(0, rrbs_pkg::NUM_TASKS - 1));
		// keep most delays short so counters expire within the run
		spread = $urandom_range(0, 99);
		if (spread < 8) dly = '0;
		else if (spread < 70) dly = rrbs_pkg::DELAY_W'($urandom_range(1, 6));
		else if (spread < 90) dly = rrbs_pkg::DELAY_W'($urandom_range(7, 40));
		else dly = rrbs_pkg::DELAY_W'($urandom_range(0, 16'hFFFF));
		send_op(op, prio, dly);
	endtask

	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			sched.check_result(m_axis_tdata);
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// kernel stopped after reset: ticks are ignored, bitmap ops still work
		send_op(rrbs_pkg::OP_TICK, 6'd0, 16'd0);
		send_op(rrbs_pkg::OP_SET, 6'd0, 16'd0);
		send_op(rrbs_pkg::OP_SET, 6'd63, 16'd0);
		send_op(rrbs_pkg::OP_SET, 6'd31, 16'd0);
		send_op(rrbs_pkg::OP_SET, 6'd32, 16'd0);
		send_op(rrbs_pkg::OP_CLEAR, 6'd63, 16'd0);
		send_op(rrbs_pkg::OP_CLEAR, 6'd32, 16'd0);
		send_op(rrbs_pkg::OP_CLEAR, 6'd31, 16'd0);
		send_op(rrbs_pkg::OP_CLEAR, 6'd0, 16'd0);
		send_op(rrbs_pkg::OP_DELAY, 6'd5, 16'd0);
		send_op(rrbs_pkg::OP_SET, 6'd5, 16'd0);
		send_op(rrbs_pkg::OP_DELAY, 6'd5, 16'd0);
		send_op(rrbs_pkg::OP_DELAY, 6'd5, 16'd2);
		send_op(rrbs_pkg::OP_DELAY, 6'd40, 16'hFFFF);
		send_op(rrbs_pkg::OP_TICK, 6'd63, 16'hFFFF);

		set_running(1'b1);
		send_op(rrbs_pkg::OP_TICK, 6'd0, 16'd0);
		send_op(rrbs_pkg::OP_TICK, 6'd0, 16'd0);
		// set ready on a delayed task leaves its counter running
		send_op(rrbs_pkg::OP_DELAY, 6'd10, 16'd3);
		send_op(rrbs_pkg::OP_SET, 6'd10, 16'd0);
		send_op(rrbs_pkg::OP_DELAY, 6'd63, 16'd1);
		send_op(rrbs_pkg::OP_TICK, 6'd0, 16'd0);
		send_op(rrbs_pkg::OP_CLEAR, 6'd10, 16'd0);
		send_op(rrbs_pkg::OP_TICK, 6'd0, 16'd0);
		send_op(rrbs_pkg::OP_TICK, 6'd0, 16'd0);

		for (int p = 0; p < PHASES; p++) begin
			set_running(PHASE_RUN[p]);
			no_idle = PHASE_QUIET[p];
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (p == 3 && n == PHASE_ITEMS / 2) drain();
				send_random();
			end
		end

		drain();
		repeat (40) @(posedge clk);
		if (sched.mismatches == 0 && sched.pending() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

[sim.f]
+incdir+src
src/rrbs_pkg.sv
src/rrbs_ram.sv
src/rrbs_front.sv
src/rrbs_back.sv
src/rtos_ready_bitmap_scheduler.sv
sim/rtos_ready_bitmap_scheduler_test.sv
